// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker in rtl/sfr_checker.sv.
// Clock and active-low reset are passed in by the user of each macro.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SFR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/sfr_pkg.sv -----
// Shared types and constants for the stream find-and-replace unit.
// No dependencies.
package sfr_pkg;

    localparam int MAX_PATTERN     = 8;
    localparam int MAX_REPLACEMENT = 8;
    localparam int MAX_RESULTS     = 8;

    localparam logic [3:0] PLEN_MAX     = 4'(MAX_PATTERN);
    localparam logic [3:0] RLEN_MAX     = 4'(MAX_REPLACEMENT);
    localparam logic [3:0] RESULTS_MAX  = 4'(MAX_RESULTS);
    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    typedef enum logic [1:0] {
        CFG_PATTERN_BYTES      = 2'd0,
        CFG_PATTERN_LENGTH     = 2'd1,
        CFG_REPLACEMENT_BYTES  = 2'd2,
        CFG_REPLACEMENT_LENGTH = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } out_item_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_SHIFT_EMIT,
        OP_REPL_START,
        OP_REPL_EMIT,
        OP_POP
    } dp_op_t;

    typedef struct packed {
        logic plen_zero;
        logic held_empty;
        logic full_match;
        logic prefix_match;
        logic flush_req;
        logic repl_done;
        logic out_empty;
        logic out_last;
    } dp_status_t;

endpackage

// ----- rtl/stream_find_replace_unit.sv -----
// Top level of the stream find-and-replace unit.
// Depends on sfr_pkg, sfr_controller and sfr_datapath.
//
// Takes one text byte per input transaction and returns 0 to 8 result
// transactions for it, the last one flagged by run_last. Each leftmost,
// non-overlapping occurrence of the pattern (register 0 bytes, register 1
// length) becomes the replacement (register 2 bytes, register 3 length);
// bytes that may start a match are held until resolved, and the held bytes
// are released after a newline or an end_of_stream byte. One byte is in
// work at a time: an item goes through a load, a scan decision, the release
// of held bytes, the replacement bytes, the flushed bytes, a flush decision
// and the delivery of its results; the scan/shift loop handles one byte per
// cycle and the output gives one result per cycle while out_ready is high.
// Configuration writes are accepted in any cycle and are meant for idle
// periods; writing the pattern or its length discards held bytes.
module stream_find_replace_unit
    import sfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  cfg_index_t  cfg_index,
    input  logic [63:0] cfg_data
);

    dp_op_t     op;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    sfr_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .status    (status),
        .op        (op),
        .in_ready  (in_ready),
        .out_valid (out_valid)
    );

    sfr_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .in_data   (in_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .out_data  (out_data)
    );

endmodule

// ----- rtl/sfr_datapath.sv -----
// Datapath: configuration registers, held-byte buffer, prefix compare and result buffer.
// Depends on sfr_pkg; driven by sfr_controller through dp_op_t commands.
module sfr_datapath
    import sfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_op_t      op,
    input  in_item_t    in_data,
    input  logic        cfg_we,
    input  cfg_index_t  cfg_index,
    input  logic [63:0] cfg_data,
    output dp_status_t  status,
    output out_item_t   out_data
);

    logic [63:0] pat_reg;
    logic [3:0]  plen_reg;
    logic [63:0] rep_reg;
    logic [3:0]  rlen_reg;

    logic [7:0]  wb_reg   [MAX_PATTERN];
    logic [7:0]  wb_next  [MAX_PATTERN];
    logic [3:0]  hc_reg, hc_next;

    logic [7:0]  ob_reg   [MAX_RESULTS];
    logic [7:0]  ob_next  [MAX_RESULTS];
    logic [3:0]  on_reg, on_next;

    logic [3:0]  ri_reg, ri_next;
    logic        flush_reg, flush_next;

    logic [MAX_PATTERN-1:0] eq_vec;
    logic [MAX_PATTERN-1:0] in_range;
    logic                   match_hc;
    logic [3:0]             hc_eff;
    logic                   emit_en;
    logic [7:0]             emit_val;

    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            eq_vec[i]   = (wb_reg[i] == pat_reg[8*i +: 8]);
            in_range[i] = (4'(i) < hc_reg);
        end
    end

    assign match_hc = &(eq_vec | ~in_range);

    assign status.plen_zero    = (plen_reg == 4'd0);
    assign status.held_empty   = (hc_reg == 4'd0);
    assign status.full_match   = (hc_reg == plen_reg) && match_hc;
    assign status.prefix_match = (hc_reg < plen_reg) && match_hc;
    assign status.flush_req    = flush_reg;
    assign status.repl_done    = (ri_reg >= rlen_reg);
    assign status.out_empty    = (on_reg == 4'd0);
    assign status.out_last     = (on_reg == 4'd1);

    assign out_data.out_byte = ob_reg[0];
    assign out_data.run_last = (on_reg == 4'd1);

    // held count is always a proper prefix; guard kept for safety
    assign hc_eff = (hc_reg >= plen_reg) ? 4'd0 : hc_reg;

    always_comb
    begin
        wb_next    = wb_reg;
        hc_next    = hc_reg;
        ri_next    = ri_reg;
        flush_next = flush_reg;
        emit_en    = 1'b0;
        emit_val   = wb_reg[0];

        case (op)
            OP_LOAD:
            begin
                flush_next = (in_data.in_byte == NEWLINE_BYTE) || in_data.end_of_stream;
                if (plen_reg == 4'd0)
                begin
                    hc_next  = 4'd0;
                    emit_en  = 1'b1;
                    emit_val = in_data.in_byte;
                end
                else
                begin
                    wb_next[hc_eff[2:0]] = in_data.in_byte;
                    hc_next = hc_eff + 4'd1;
                end
            end
            OP_SHIFT_EMIT:
            begin
                emit_en  = 1'b1;
                emit_val = wb_reg[0];
                for (int i = 0; i < MAX_PATTERN - 1; i++)
                begin
                    wb_next[i] = wb_reg[i+1];
                end
                hc_next = hc_reg - 4'd1;
            end
            OP_REPL_START:
            begin
                hc_next = 4'd0;
                ri_next = 4'd0;
            end
            OP_REPL_EMIT:
            begin
                emit_en  = 1'b1;
                emit_val = rep_reg[8*ri_reg[2:0] +: 8];
                ri_next  = ri_reg + 4'd1;
            end
            default:
            begin
            end
        endcase

        if (cfg_we && (cfg_index == CFG_PATTERN_BYTES || cfg_index == CFG_PATTERN_LENGTH))
        begin
            hc_next = 4'd0;
        end
    end

    always_comb
    begin
        ob_next = ob_reg;
        on_next = on_reg;
        if (op == OP_LOAD)
        begin
            on_next = 4'd0;
            if (emit_en)
            begin
                ob_next[0] = emit_val;
                on_next    = 4'd1;
            end
        end
        else if (op == OP_POP)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                ob_next[i] = ob_reg[i+1];
            end
            on_next = on_reg - 4'd1;
        end
        else if (emit_en && (on_reg < RESULTS_MAX))
        begin
            ob_next[on_reg[2:0]] = emit_val;
            on_next = on_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg   <= '0;
            plen_reg  <= '0;
            rep_reg   <= '0;
            rlen_reg  <= '0;
            hc_reg    <= '0;
            on_reg    <= '0;
            ri_reg    <= '0;
            flush_reg <= 1'b0;
        end
        else
        begin
            hc_reg    <= hc_next;
            on_reg    <= on_next;
            ri_reg    <= ri_next;
            flush_reg <= flush_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PATTERN_BYTES:
                    begin
                        pat_reg <= cfg_data;
                    end
                    CFG_PATTERN_LENGTH:
                    begin
                        plen_reg <= (cfg_data[3:0] > PLEN_MAX) ? PLEN_MAX : cfg_data[3:0];
                    end
                    CFG_REPLACEMENT_BYTES:
                    begin
                        rep_reg <= cfg_data;
                    end
                    CFG_REPLACEMENT_LENGTH:
                    begin
                        rlen_reg <= (cfg_data[3:0] > RLEN_MAX) ? RLEN_MAX : cfg_data[3:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wb_reg <= wb_next;
        ob_reg <= ob_next;
    end

endmodule

// ----- rtl/sfr_controller.sv -----
// Controller state machine: sequences load, scan, replacement, flush and drain.
// Depends on sfr_pkg; commands sfr_datapath through dp_op_t.
module sfr_controller
    import sfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_op_t     op,
    output logic       in_ready,
    output logic       out_valid
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REPL,
        ST_FLUSH,
        ST_DRAIN
    } state_t;

    state_t state_reg, state_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_DRAIN);

    always_comb
    begin
        op         = OP_NONE;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op         = OP_LOAD;
                    state_next = status.plen_zero ? ST_DRAIN : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.held_empty || status.prefix_match)
                begin
                    state_next = ST_FLUSH;
                end
                else if (status.full_match)
                begin
                    op         = OP_REPL_START;
                    state_next = ST_REPL;
                end
                else
                begin
                    op = OP_SHIFT_EMIT;
                end
            end
            ST_REPL:
            begin
                if (status.repl_done)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    op = OP_REPL_EMIT;
                end
            end
            ST_FLUSH:
            begin
                if (status.flush_req && !status.held_empty)
                begin
                    op = OP_SHIFT_EMIT;
                end
                else
                begin
                    state_next = status.out_empty ? ST_IDLE : ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (out_ready)
                begin
                    op = OP_POP;
                    if (status.out_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/sfr_checker.sv -----
// Port-level checker for stream_find_replace_unit, bound to the top level.
// Depends on sfr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sfr_checker
    import sfr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input out_item_t   out_data
);

    // no new input transaction while results are still being delivered
    `SFR_ASSERT_IMPLY(a_no_accept_in_drain, clk, rst_n, in_valid && in_ready, !out_valid)

    // one byte in work at a time
    `SFR_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)

    // after the flagged last result the unit is ready again
    `SFR_ASSERT_NEXT(a_last_frees_input, clk, rst_n, out_valid && out_ready && out_data.run_last, in_ready && !out_valid)

    `SFR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind stream_find_replace_unit sfr_checker u_sfr_checker (.*);

// ----- tb/sfr_checker.sv -----
// Scoreboard for the stream find-and-replace unit: watches all three channels,
// predicts each result transaction and compares it field by field.
// Depends on sfr_pkg.
module sfr_scoreboard
    import sfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  in_item_t    in_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  out_item_t   out_data,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  cfg_index_t  cfg_index,
    input  logic [63:0] cfg_data,
    output int unsigned mismatch_count,
    output int unsigned outstanding,
    output int unsigned bytes_out
);

    logic [63:0] pat_word;
    logic [3:0]  pat_len;
    logic [63:0] rep_word;
    logic [3:0]  rep_len;
    logic [7:0]  held_buf [MAX_PATTERN];
    int unsigned held_num;
    out_item_t   burst [$];
    out_item_t   expected_bytes [$];
    int unsigned errs;
    int unsigned seen;

    function automatic bit holds_prefix(int unsigned n);
        for (int unsigned i = 0; i < n; i++)
        begin
            if (held_buf[i] !== pat_word[8*i +: 8])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void emit_byte(logic [7:0] value);
        if (burst.size() < MAX_RESULTS)
            burst.push_back(out_item_t'{value, 1'b0});
    endfunction

    function automatic void rewrite_byte(in_item_t item);
        int unsigned plen;
        int unsigned rlen;
        bit settled;
        plen = (pat_len > PLEN_MAX) ? MAX_PATTERN : int'(pat_len);
        rlen = (rep_len > RLEN_MAX) ? MAX_REPLACEMENT : int'(rep_len);
        burst.delete();
        if (plen == 0)
        begin
            held_num = 0;
            emit_byte(item.in_byte);
        end
        else
        begin
            if (held_num >= plen)
                held_num = 0;
            held_buf[held_num] = item.in_byte;
            held_num++;
            settled = 1'b0;
            while (held_num > 0 && !settled)
            begin
                if (held_num == plen && holds_prefix(plen))
                begin
                    for (int unsigned i = 0; i < rlen; i++)
                        emit_byte(rep_word[8*i +: 8]);
                    held_num = 0;
                    settled = 1'b1;
                end
                else if (held_num < plen && holds_prefix(held_num))
                begin
                    settled = 1'b1;
                end
                else
                begin
                    // oldest byte can no longer start a match
                    emit_byte(held_buf[0]);
                    for (int unsigned i = 1; i < held_num; i++)
                        held_buf[i-1] = held_buf[i];
                    held_num--;
                end
            end
            if (item.in_byte == NEWLINE_BYTE || item.end_of_stream)
            begin
                for (int unsigned i = 0; i < held_num; i++)
                    emit_byte(held_buf[i]);
                held_num = 0;
            end
        end
        if (burst.size() > 0)
            burst[burst.size()-1].run_last = 1'b1;
        foreach (burst[i])
            expected_bytes.push_back(burst[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            pat_word = '0;
            pat_len  = '0;
            rep_word = '0;
            rep_len  = '0;
            held_num = 0;
            errs     = 0;
            seen     = 0;
            expected_bytes.delete();
            mismatch_count <= 0;
            outstanding    <= 0;
            bytes_out      <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PATTERN_BYTES:
                    begin
                        pat_word = cfg_data;
                        held_num = 0;
                    end
                    CFG_PATTERN_LENGTH:
                    begin
                        pat_len  = cfg_data[3:0];
                        held_num = 0;
                    end
                    CFG_REPLACEMENT_BYTES:  rep_word = cfg_data;
                    CFG_REPLACEMENT_LENGTH: rep_len  = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                rewrite_byte(in_data);
            if (out_valid && out_ready)
            begin
                seen++;
                if (expected_bytes.size() == 0)
                begin
                    $error("unexpected result transaction: out_byte %02h run_last %b",
                           out_data.out_byte, out_data.run_last);
                    errs++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_data.out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %02h, got %02h",
                               want.out_byte, out_data.out_byte);
                        errs++;
                    end
                    if (out_data.run_last !== want.run_last)
                    begin
                        $error("run_last: expected %b, got %b",
                               want.run_last, out_data.run_last);
                        errs++;
                    end
                end
            end
            mismatch_count <= errs;
            outstanding    <= expected_bytes.size();
            bytes_out      <= seen;
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top for stream_find_replace_unit: clock, reset, register setup,
// directed and random byte streams, and the verdict.
// Depends on sfr_pkg, stream_find_replace_unit and sfr_scoreboard.
module tb_top
    import sfr_pkg::*;
();

    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned PHASE_ITEMS  = 50;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    in_item_t    in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_index = CFG_PATTERN_BYTES;
    logic [63:0] cfg_data  = '0;

    int unsigned mismatch_count;
    int unsigned outstanding;
    int unsigned bytes_out;

    bit          steady = 1'b0;
    int unsigned items_sent = 0;
    int unsigned settings_used = 0;
    int unsigned quiet_cycles = 0;
    int unsigned pat_len = 0;
    logic [63:0] pat_word = '0;
    logic [7:0]  alpha [4];

    always #10 clk = ~clk;

    stream_find_replace_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sfr_scoreboard u_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding),
        .bytes_out      (bytes_out)
    );

    always @(posedge clk)
    begin
        if (rst_n)
            out_ready <= steady || ($urandom_range(0, 99) >= 7);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_item(input logic [7:0] b, input logic eos);
        if (!steady && $urandom_range(0, 99) < 7)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 3) != 0);
        end
        in_valid <= 1'b1;
        in_data  <= in_item_t'{b, eos};
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    function automatic logic rare_eos();
        return ($urandom_range(0, 49) == 0);
    endfunction

    // drop valid, wait for every predicted byte, then allow for the pipeline
    task automatic settle(input int unsigned tail);
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic configure(input logic [63:0] p, input logic [63:0] pl,
                             input logic [63:0] r, input logic [63:0] rl);
        settle(DRAIN_CYCLES);
        write_reg(CFG_PATTERN_BYTES, p);
        write_reg(CFG_PATTERN_LENGTH, pl);
        write_reg(CFG_REPLACEMENT_BYTES, r);
        write_reg(CFG_REPLACEMENT_LENGTH, rl);
        cfg_valid <= 1'b0;
        pat_word = p;
        pat_len  = (pl[3:0] > PLEN_MAX) ? MAX_PATTERN : int'(pl[3:0]);
        settings_used++;
    endtask

    initial
    begin
        logic [63:0] p;
        logic [63:0] pl;
        logic [63:0] rl;
        int unsigned phase_end;
        int unsigned pick;
        int unsigned cut;
        bit paused;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: empty pattern passes everything through
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(NEWLINE_BYTE, 1'b1);

        // "ab" -> "XYZ", with a false start and a flush at end of stream
        configure(64'h6261, 64'd2, 64'h5A5958, 64'd3);
        send_item(8'h61, 1'b0);
        send_item(8'h62, 1'b0);
        send_item(8'h61, 1'b0);
        send_item(8'h61, 1'b0);
        send_item(8'h62, 1'b0);
        send_item(8'h61, 1'b1);

        // pattern ending in a newline, deleted
        configure(64'h0A78, 64'd2, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
        send_item(8'h78, 1'b0);
        send_item(NEWLINE_BYTE, 1'b0);
        send_item(8'h78, 1'b0);
        send_item(8'h78, 1'b0);
        send_item(NEWLINE_BYTE, 1'b0);

        // oversized lengths clamp to eight bytes
        configure(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFF9,
                  64'h0123_4567_89AB_CDEF, 64'd15);
        repeat (8) send_item(8'hFF, 1'b0);
        repeat (3) send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b1);

        // held byte then a pattern rewrite: the held byte is dropped
        send_item(8'hFF, 1'b0);
        configure(64'h0000_0000_00FF_FFFF, 64'd3, 64'h0, 64'd1);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b1);

        paused = 1'b0;
        for (int ph = 0; ph < 6; ph++)
        begin
            for (int k = 0; k < 4; k++)
                alpha[k] = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 2) == 0)
                alpha[3] = NEWLINE_BYTE;
            case (ph)
                0:
                begin
                    pl = 64'd1;
                    rl = 64'($urandom_range(0, 8));
                end
                1:
                begin
                    pl = 64'd8;
                    rl = 64'd8;
                end
                2:
                begin
                    pl = 64'd0;
                    rl = 64'($urandom_range(0, 8));
                end
                3:
                begin
                    pl = 64'($urandom_range(9, 15));
                    rl = 64'($urandom_range(9, 15));
                end
                default:
                begin
                    pl = 64'($urandom_range(1, 8));
                    rl = 64'($urandom_range(0, 8));
                end
            endcase
            p = {$urandom, $urandom};
            for (int k = 0; k < 8; k++)
            begin
                if ($urandom_range(0, 9) != 0)
                    p[8*k +: 8] = alpha[$urandom_range(0, 3)];
            end
            steady <= (ph == 1);
            configure(p, pl, {$urandom, $urandom}, rl);

            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                if (ph == 2 && !paused && items_sent + 25 >= phase_end)
                begin
                    settle(0);
                    paused = 1'b1;
                end
                pick = $urandom_range(0, 99);
                if (pick < 55 && pat_len > 0)
                begin
                    // whole pattern, or a broken-off prefix of it
                    cut = (pick < 40) ? pat_len : $urandom_range(1, pat_len);
                    for (int k = 0; k < cut; k++)
                        send_item(pat_word[8*k +: 8], rare_eos());
                end
                else if (pick < 90)
                    send_item(alpha[$urandom_range(0, 3)], rare_eos());
                else if (pick < 97)
                    send_item(8'($urandom_range(0, 255)), rare_eos());
                else
                    send_item(NEWLINE_BYTE, rare_eos());
            end
        end

        steady <= 1'b0;
        settle(DRAIN_CYCLES);
        $display("covered %0d input bytes and %0d output bytes over %0d register settings,",
                 items_sent, bytes_out, settings_used);
        $display("including empty, one-byte, full-length and oversized patterns");
        if (mismatch_count == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
